>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fpsm_pkg.sv
package fpsm_pkg;

	typedef enum logic [2:0] {
		PH_DISARMED   = 3'd0,
		PH_ARMED      = 3'd1,
		PH_READY      = 3'd2,
		PH_TAKING_OFF = 3'd3,
		PH_FLYING     = 3'd4,
		PH_LANDING    = 3'd5,
		PH_TESTING    = 3'd6
	} phase_t;

	localparam logic [1:0] SW_DISARM = 2'd0;
	localparam logic [1:0] SW_ARM    = 2'd1;
	localparam logic [1:0] SW_LAND   = 2'd2;
	localparam logic [1:0] SW_OTHER  = 2'd3;

	localparam logic signed [7:0] STICK_LOW  = -8'sd90;
	localparam logic signed [7:0] STICK_HIGH = 8'sd90;

	localparam int unsigned ADDR_W = 5;

	localparam logic [2:0] REG_TAKEOFF_HEIGHT   = 3'd0;
	localparam logic [2:0] REG_TOUCHDOWN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_LANDING_HEIGHT   = 3'd2;
	localparam logic [2:0] REG_TILT_LIMIT       = 3'd3;
	localparam logic [2:0] REG_HOLD_TICKS       = 3'd4;
	localparam logic [2:0] REG_LIFTOFF_THR      = 3'd5;

	localparam logic [15:0] RST_TAKEOFF_HEIGHT   = 16'd100;
	localparam logic [15:0] RST_TOUCHDOWN_HEIGHT = 16'd10;
	localparam logic [15:0] RST_LANDING_HEIGHT   = 16'd500;
	localparam logic [14:0] RST_TILT_LIMIT       = 15'd6000;
	localparam logic [5:0]  RST_HOLD_TICKS       = 6'd50;
	localparam logic signed [7:0] RST_LIFTOFF_THR = 8'sd5;

	typedef struct packed {
		logic [15:0]       takeoff_height;
		logic [15:0]       touchdown_height;
		logic [15:0]       landing_allowed_height;
		logic [14:0]       tilt_limit;
		logic [5:0]        landing_hold_ticks;
		logic signed [7:0] liftoff_thr;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         rc_switch;
		logic signed [7:0]  stick_roll;
		logic signed [7:0]  stick_pitch;
		logic signed [7:0]  stick_yaw;
		logic signed [7:0]  stick_throttle;
		logic [15:0]        ground_range;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic               calibration_pass;
	} item_t;

	typedef struct packed {
		phase_t phase;
		logic   changed;
	} result_t;

endpackage

>>> hw/rtl/flight_phase_state_machine.sv
// Path: an accepted item waits in the input register; its result then loads the result
// register, which raises out_valid; that load waits while a held result is not taken.
// Throughput: one item per cycle unless out_ready stalls; phase logic is combinational.
// A pending result does not block intake while the input register is free.
// Reset (arst_n low, asynchronous): phase disarmed, switch history 0, not calibrated,
// landing hold counter 50, registers at their reset values, both stages empty.
module flight_phase_state_machine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fpsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   rc_switch,
	input  logic signed [7:0]            stick_roll,
	input  logic signed [7:0]            stick_pitch,
	input  logic signed [7:0]            stick_yaw,
	input  logic signed [7:0]            stick_throttle,
	input  logic [15:0]                  ground_range,
	input  logic signed [15:0]           roll_angle,
	input  logic signed [15:0]           pitch_angle,
	input  logic                         calibration_pass,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   flight_phase,
	output logic                         phase_changed
);

	fpsm_pkg::cfg_t    cfg;
	fpsm_pkg::item_t   item_s1;
	logic              valid_s1;
	fpsm_pkg::result_t res;
	fpsm_pkg::result_t res_q;
	logic              out_valid_q;
	logic              step;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	fpsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fpsm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rc_switch        <= rc_switch;
			item_s1.stick_roll       <= stick_roll;
			item_s1.stick_pitch      <= stick_pitch;
			item_s1.stick_yaw        <= stick_yaw;
			item_s1.stick_throttle   <= stick_throttle;
			item_s1.ground_range     <= ground_range;
			item_s1.roll_angle       <= roll_angle;
			item_s1.pitch_angle      <= pitch_angle;
			item_s1.calibration_pass <= calibration_pass;
		end
		if (step)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign flight_phase  = res_q.phase;
	assign phase_changed = res_q.changed;

endmodule

>>> hw/rtl/fpsm_regs.sv
module fpsm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fpsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output fpsm_pkg::cfg_t               cfg
);

	fpsm_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.takeoff_height         <= fpsm_pkg::RST_TAKEOFF_HEIGHT;
			cfg_q.touchdown_height       <= fpsm_pkg::RST_TOUCHDOWN_HEIGHT;
			cfg_q.landing_allowed_height <= fpsm_pkg::RST_LANDING_HEIGHT;
			cfg_q.tilt_limit             <= fpsm_pkg::RST_TILT_LIMIT;
			cfg_q.landing_hold_ticks     <= fpsm_pkg::RST_HOLD_TICKS;
			cfg_q.liftoff_thr            <= fpsm_pkg::RST_LIFTOFF_THR;
		end else if (wr_en) begin
			case (reg_idx)
				fpsm_pkg::REG_TAKEOFF_HEIGHT:   cfg_q.takeoff_height <= pwdata[15:0];
				fpsm_pkg::REG_TOUCHDOWN_HEIGHT: cfg_q.touchdown_height <= pwdata[15:0];
				fpsm_pkg::REG_LANDING_HEIGHT:   cfg_q.landing_allowed_height <= pwdata[15:0];
				fpsm_pkg::REG_TILT_LIMIT:       cfg_q.tilt_limit <= pwdata[14:0];
				fpsm_pkg::REG_HOLD_TICKS:       cfg_q.landing_hold_ticks <= pwdata[5:0];
				fpsm_pkg::REG_LIFTOFF_THR:      cfg_q.liftoff_thr <= $signed(pwdata[7:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fpsm_pkg::REG_TAKEOFF_HEIGHT:   prdata = {16'd0, cfg_q.takeoff_height};
			fpsm_pkg::REG_TOUCHDOWN_HEIGHT: prdata = {16'd0, cfg_q.touchdown_height};
			fpsm_pkg::REG_LANDING_HEIGHT:   prdata = {16'd0, cfg_q.landing_allowed_height};
			fpsm_pkg::REG_TILT_LIMIT:       prdata = {17'd0, cfg_q.tilt_limit};
			fpsm_pkg::REG_HOLD_TICKS:       prdata = {26'd0, cfg_q.landing_hold_ticks};
			fpsm_pkg::REG_LIFTOFF_THR:
				prdata = {{24{cfg_q.liftoff_thr[7]}}, cfg_q.liftoff_thr};
			default:                        prdata = 32'd0;
		endcase
	end

endmodule

>>> hw/rtl/fpsm_core.sv
module fpsm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  fpsm_pkg::item_t   item,
	input  fpsm_pkg::cfg_t    cfg,
	output fpsm_pkg::result_t res
);

	fpsm_pkg::phase_t phase_q;
	logic [1:0]       last_sw_q;
	logic             cal_q;
	logic [5:0]       hold_q;

	fpsm_pkg::phase_t ph;
	logic [5:0]       hold_d;
	logic             cal_d;
	logic [15:0]      roll_mag;
	logic [15:0]      pitch_mag;
	logic             low_range;
	logic             thr_low;
	logic signed [7:0] thr;

	always_comb begin
		cal_d     = cal_q | item.calibration_pass;
		thr       = $signed(item.stick_throttle);
		roll_mag  = item.roll_angle[15] ? (~$unsigned(item.roll_angle) + 16'd1)
		                                : $unsigned(item.roll_angle);
		pitch_mag = item.pitch_angle[15] ? (~$unsigned(item.pitch_angle) + 16'd1)
		                                 : $unsigned(item.pitch_angle);
		low_range = item.ground_range < cfg.touchdown_height;
		thr_low   = thr == fpsm_pkg::STICK_LOW;
		ph        = phase_q;
		hold_d    = hold_q;

		if (item.rc_switch == fpsm_pkg::SW_DISARM)
			ph = fpsm_pkg::PH_DISARMED;

		if (item.rc_switch == fpsm_pkg::SW_ARM && last_sw_q == fpsm_pkg::SW_DISARM && cal_d)
			ph = fpsm_pkg::PH_ARMED;

		if (ph == fpsm_pkg::PH_ARMED) begin
			if ($signed(item.stick_yaw) == fpsm_pkg::STICK_LOW && thr_low &&
			    $signed(item.stick_roll) == fpsm_pkg::STICK_HIGH &&
			    $signed(item.stick_pitch) == fpsm_pkg::STICK_LOW)
				ph = fpsm_pkg::PH_READY;
		end

		if (ph == fpsm_pkg::PH_READY) begin
			if (thr > $signed(cfg.liftoff_thr))
				ph = (item.rc_switch == fpsm_pkg::SW_ARM) ? fpsm_pkg::PH_TAKING_OFF
				                                         : fpsm_pkg::PH_TESTING;
		end

		if (ph == fpsm_pkg::PH_TAKING_OFF) begin
			if (item.ground_range > cfg.takeoff_height)
				ph = fpsm_pkg::PH_FLYING;
		end

		if (ph == fpsm_pkg::PH_FLYING) begin
			if (low_range && thr_low)
				ph = fpsm_pkg::PH_DISARMED;
			if (item.rc_switch == fpsm_pkg::SW_LAND && last_sw_q != fpsm_pkg::SW_LAND &&
			    item.ground_range > cfg.landing_allowed_height)
				ph = fpsm_pkg::PH_LANDING;
		end

		if (ph == fpsm_pkg::PH_TAKING_OFF || ph == fpsm_pkg::PH_FLYING) begin
			if (roll_mag > {1'b0, cfg.tilt_limit} || pitch_mag > {1'b0, cfg.tilt_limit})
				ph = fpsm_pkg::PH_DISARMED;
		end

		if (ph == fpsm_pkg::PH_LANDING) begin
			if (low_range) begin
				if (hold_q == 6'd0)
					ph = fpsm_pkg::PH_DISARMED;
				else
					hold_d = hold_q - 6'd1;
			end else begin
				hold_d = cfg.landing_hold_ticks;
			end
			if (item.rc_switch != fpsm_pkg::SW_LAND)
				ph = fpsm_pkg::PH_FLYING;
		end

		res.phase   = ph;
		res.changed = ph != phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fpsm_pkg::PH_DISARMED;
			last_sw_q <= fpsm_pkg::SW_DISARM;
			cal_q     <= 1'b0;
			hold_q    <= fpsm_pkg::RST_HOLD_TICKS;
		end else if (step) begin
			phase_q   <= ph;
			last_sw_q <= item.rc_switch;
			cal_q     <= cal_d;
			hold_q    <= hold_d;
		end
	end

endmodule

>>> hw/rtl/fpsm_checker.sv
`include "assert_macros.svh"

module fpsm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] flight_phase,
	input logic       phase_changed
);

	logic [2:0] prev_phase_q;
	logic [1:0] occ_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= 3'd0;
			occ_q        <= 2'd0;
		end else begin
			if (out_acc)
				prev_phase_q <= flight_phase;
			if (in_acc && !out_acc)
				occ_q <= occ_q + 2'd1;
			else if (out_acc && !in_acc)
				occ_q <= occ_q - 2'd1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(flight_phase) && $stable(phase_changed), "result item dropped or changed while stalled")
	`ASSERT_IMPL(a_changed_flag, clk, arst_n, out_valid, phase_changed == (flight_phase != prev_phase_q), "phase_changed disagrees with previous phase")
	`ASSERT_IMPL(a_occ_bound, clk, arst_n, 1'b1, occ_q <= 2'd2, "more than two items in flight")
	`ASSERT_IMPL(a_no_invent, clk, arst_n, out_valid, occ_q != 2'd0, "result item without an accepted input item")

endmodule

bind flight_phase_state_machine fpsm_checker u_fpsm_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 1000;
	localparam int RX_HOLD_CYCLES = 40;
	localparam int RANDOM_TICKS = 850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [fpsm_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] rc_switch = '0;
	logic signed [7:0] stick_roll = '0;
	logic signed [7:0] stick_pitch = '0;
	logic signed [7:0] stick_yaw = '0;
	logic signed [7:0] stick_throttle = '0;
	logic [15:0] ground_range = '0;
	logic signed [15:0] roll_angle = '0;
	logic signed [15:0] pitch_angle = '0;
	logic calibration_pass = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] flight_phase;
	logic phase_changed;

	flight_phase_state_machine uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rc_switch(rc_switch),
		.stick_roll(stick_roll),
		.stick_pitch(stick_pitch),
		.stick_yaw(stick_yaw),
		.stick_throttle(stick_throttle),
		.ground_range(ground_range),
		.roll_angle(roll_angle),
		.pitch_angle(pitch_angle),
		.calibration_pass(calibration_pass),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.flight_phase(flight_phase),
		.phase_changed(phase_changed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the registers
	int cfg_takeoff_h = fpsm_pkg::RST_TAKEOFF_HEIGHT;
	int cfg_touchdown_h = fpsm_pkg::RST_TOUCHDOWN_HEIGHT;
	int cfg_land_h = fpsm_pkg::RST_LANDING_HEIGHT;
	int cfg_tilt = fpsm_pkg::RST_TILT_LIMIT;
	int cfg_hold = fpsm_pkg::RST_HOLD_TICKS;
	int cfg_thr = fpsm_pkg::RST_LIFTOFF_THR;

	// Phase tracker state
	fpsm_pkg::phase_t cur_phase = fpsm_pkg::PH_DISARMED;
	fpsm_pkg::phase_t prev_phase = fpsm_pkg::PH_DISARMED;
	logic [1:0] prev_switch = fpsm_pkg::SW_DISARM;
	bit calibrated = 1'b0;
	int hold_cnt = fpsm_pkg::RST_HOLD_TICKS;

	fpsm_pkg::result_t pending_results[$];
	int mismatch_cnt = 0;
	int ticks_sent = 0;
	int idle_cycles = 0;
	bit tx_fast = 1'b0;
	bit rx_fast = 1'b0;
	bit rx_hold_req = 1'b0;
	fpsm_pkg::item_t seen_item;

	function automatic fpsm_pkg::result_t next_phase(fpsm_pkg::item_t it);
		fpsm_pkg::result_t r;
		int thr;
		int rng;
		int aroll;
		int apitch;
		thr = $signed(it.stick_throttle);
		rng = it.ground_range;
		aroll = $signed(it.roll_angle);
		apitch = $signed(it.pitch_angle);
		if (aroll < 0) aroll = -aroll;
		if (apitch < 0) apitch = -apitch;

		if (it.calibration_pass) calibrated = 1'b1;
		if (it.rc_switch == fpsm_pkg::SW_DISARM) cur_phase = fpsm_pkg::PH_DISARMED;
		if (it.rc_switch == fpsm_pkg::SW_ARM && prev_switch == fpsm_pkg::SW_DISARM &&
				calibrated)
			cur_phase = fpsm_pkg::PH_ARMED;
		if (cur_phase == fpsm_pkg::PH_ARMED && $signed(it.stick_yaw) == fpsm_pkg::STICK_LOW &&
				thr == fpsm_pkg::STICK_LOW && $signed(it.stick_roll) == fpsm_pkg::STICK_HIGH &&
				$signed(it.stick_pitch) == fpsm_pkg::STICK_LOW)
			cur_phase = fpsm_pkg::PH_READY;
		if (cur_phase == fpsm_pkg::PH_READY && thr > cfg_thr) begin
			if (it.rc_switch == fpsm_pkg::SW_ARM) cur_phase = fpsm_pkg::PH_TAKING_OFF;
			else cur_phase = fpsm_pkg::PH_TESTING;
		end
		if (cur_phase == fpsm_pkg::PH_TAKING_OFF && rng > cfg_takeoff_h)
			cur_phase = fpsm_pkg::PH_FLYING;
		if (cur_phase == fpsm_pkg::PH_FLYING) begin
			if (rng < cfg_touchdown_h && thr == fpsm_pkg::STICK_LOW)
				cur_phase = fpsm_pkg::PH_DISARMED;
			if (it.rc_switch == fpsm_pkg::SW_LAND && prev_switch != fpsm_pkg::SW_LAND &&
					rng > cfg_land_h)
				cur_phase = fpsm_pkg::PH_LANDING;
		end
		if ((cur_phase == fpsm_pkg::PH_TAKING_OFF || cur_phase == fpsm_pkg::PH_FLYING) &&
				(aroll > cfg_tilt || apitch > cfg_tilt))
			cur_phase = fpsm_pkg::PH_DISARMED;
		if (cur_phase == fpsm_pkg::PH_LANDING) begin
			if (rng < cfg_touchdown_h) begin
				if (hold_cnt < 1) cur_phase = fpsm_pkg::PH_DISARMED;
				if (hold_cnt > 0) hold_cnt--;
			end else begin
				hold_cnt = cfg_hold;
			end
			// leaving landing wins over a disarm in the same tick
			if (it.rc_switch != fpsm_pkg::SW_LAND) cur_phase = fpsm_pkg::PH_FLYING;
		end

		prev_switch = it.rc_switch;
		r.phase = cur_phase;
		r.changed = (cur_phase != prev_phase);
		prev_phase = cur_phase;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			seen_item.rc_switch = rc_switch;
			seen_item.stick_roll = stick_roll;
			seen_item.stick_pitch = stick_pitch;
			seen_item.stick_yaw = stick_yaw;
			seen_item.stick_throttle = stick_throttle;
			seen_item.ground_range = ground_range;
			seen_item.roll_angle = roll_angle;
			seen_item.pitch_angle = pitch_angle;
			seen_item.calibration_pass = calibration_pass;
			pending_results.push_back(next_phase(seen_item));
		end
	end

	always @(posedge clk) begin
		fpsm_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected item, expected none, actual phase %0d changed %0b",
					$time, flight_phase, phase_changed);
			end else begin
				want = pending_results.pop_front();
				if (flight_phase !== want.phase) begin
					mismatch_cnt++;
					$display("%0t: flight_phase expected %0d actual %0d",
						$time, want.phase, flight_phase);
				end
				if (phase_changed !== want.changed) begin
					mismatch_cnt++;
					$display("%0t: phase_changed expected %0b actual %0b",
						$time, want.changed, phase_changed);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[flight_phase_state_machine] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stalls, plus one long hold on request
	initial begin
		int gap;
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = rx_fast ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_tick(input fpsm_pkg::item_t it);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rc_switch <= it.rc_switch;
		stick_roll <= it.stick_roll;
		stick_pitch <= it.stick_pitch;
		stick_yaw <= it.stick_yaw;
		stick_throttle <= it.stick_throttle;
		ground_range <= it.ground_range;
		roll_angle <= it.roll_angle;
		pitch_angle <= it.pitch_angle;
		calibration_pass <= it.calibration_pass;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			fpsm_pkg::REG_TAKEOFF_HEIGHT: cfg_takeoff_h = val[15:0];
			fpsm_pkg::REG_TOUCHDOWN_HEIGHT: cfg_touchdown_h = val[15:0];
			fpsm_pkg::REG_LANDING_HEIGHT: cfg_land_h = val[15:0];
			fpsm_pkg::REG_TILT_LIMIT: cfg_tilt = val[14:0];
			fpsm_pkg::REG_HOLD_TICKS: cfg_hold = val[5:0];
			fpsm_pkg::REG_LIFTOFF_THR: cfg_thr = $signed(val[7:0]);
			default: ;
		endcase
	endtask

	task automatic reg_check(input logic [2:0] idx, input logic [31:0] want,
			input logic [31:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (want & mask)) begin
			mismatch_cnt++;
			$display("%0t: register %0d expected %0h actual %0h",
				$time, idx, want & mask, prdata & mask);
		end
	endtask

	task automatic bus_idle();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int to_h, input int td_h, input int land_h,
			input int tilt, input int hold, input int thr);
		drain();
		reg_write(fpsm_pkg::REG_TAKEOFF_HEIGHT, to_h);
		reg_write(fpsm_pkg::REG_TOUCHDOWN_HEIGHT, td_h);
		reg_write(fpsm_pkg::REG_LANDING_HEIGHT, land_h);
		reg_write(fpsm_pkg::REG_TILT_LIMIT, tilt);
		reg_write(fpsm_pkg::REG_HOLD_TICKS, hold);
		reg_write(fpsm_pkg::REG_LIFTOFF_THR, thr);
		reg_check(fpsm_pkg::REG_TAKEOFF_HEIGHT, to_h, 32'hFFFF);
		reg_check(fpsm_pkg::REG_TOUCHDOWN_HEIGHT, td_h, 32'hFFFF);
		reg_check(fpsm_pkg::REG_LANDING_HEIGHT, land_h, 32'hFFFF);
		reg_check(fpsm_pkg::REG_TILT_LIMIT, tilt, 32'h7FFF);
		reg_check(fpsm_pkg::REG_HOLD_TICKS, hold, 32'h3F);
		reg_check(fpsm_pkg::REG_LIFTOFF_THR, thr, 32'hFF);
		bus_idle();
	endtask

	function automatic fpsm_pkg::item_t quiet_tick(input logic [1:0] sw);
		fpsm_pkg::item_t t;
		t = '0;
		t.rc_switch = sw;
		return t;
	endfunction

	function automatic fpsm_pkg::item_t with_pattern(input fpsm_pkg::item_t t);
		t.stick_yaw = fpsm_pkg::STICK_LOW;
		t.stick_throttle = fpsm_pkg::STICK_LOW;
		t.stick_roll = fpsm_pkg::STICK_HIGH;
		t.stick_pitch = fpsm_pkg::STICK_LOW;
		return t;
	endfunction

	function automatic fpsm_pkg::item_t noise_tick();
		fpsm_pkg::item_t t;
		t.rc_switch = 2'($urandom_range(0, 3));
		t.stick_roll = 8'($urandom);
		t.stick_pitch = 8'($urandom);
		t.stick_yaw = 8'($urandom);
		t.stick_throttle = 8'($urandom);
		t.ground_range = 16'($urandom);
		t.roll_angle = 16'($urandom);
		t.pitch_angle = 16'($urandom);
		t.calibration_pass = 1'($urandom_range(0, 1));
		return t;
	endfunction

	function automatic int near_value(input int v);
		int r;
		r = v + $urandom_range(0, 2) - 1;
		if (r < 0) r = 0;
		if (r > 65535) r = 65535;
		return r;
	endfunction

	function automatic int above(input int v);
		int span;
		if (v >= 65535) return 65535;
		span = 65534 - v;
		if (span > 300) span = 300;
		return v + 1 + $urandom_range(0, span);
	endfunction

	function automatic int pick_range();
		case ($urandom_range(0, 9))
			0: return near_value(cfg_takeoff_h);
			1: return near_value(cfg_touchdown_h);
			2: return near_value(cfg_land_h);
			3: return 0;
			4: return 65535;
			5: return $urandom_range(0, 65535);
			default: return $urandom_range(0, 1200);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_angle();
		int a;
		int lim;
		lim = (cfg_tilt > 18000) ? 18000 : cfg_tilt;
		case ($urandom_range(0, 11))
			0: return 16'($urandom);
			1: a = (cfg_tilt >= 32767) ? 32767 : cfg_tilt + 1;
			2: a = cfg_tilt;
			default: a = $urandom_range(0, lim);
		endcase
		if ($urandom_range(0, 1)) a = -a;
		return 16'(a);
	endfunction

	// Mostly well-behaved tick for a scripted flight, with the odd stray switch
	function automatic fpsm_pkg::item_t flight_tick(input logic [1:0] sw);
		fpsm_pkg::item_t t;
		t = noise_tick();
		t.rc_switch = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : sw;
		t.ground_range = 16'(pick_range());
		t.roll_angle = pick_angle();
		t.pitch_angle = pick_angle();
		t.calibration_pass = ($urandom_range(0, 15) == 0);
		return t;
	endfunction

	task automatic fly();
		fpsm_pkg::item_t t;
		int n;
		send_tick(flight_tick(fpsm_pkg::SW_DISARM));
		t = flight_tick(fpsm_pkg::SW_ARM);
		if ($urandom_range(0, 9) != 0) t.calibration_pass = 1'b1;
		send_tick(t);
		t = flight_tick(fpsm_pkg::SW_ARM);
		if ($urandom_range(0, 9) != 0) t = with_pattern(t);
		send_tick(t);
		t = flight_tick(($urandom_range(0, 4) == 0) ? fpsm_pkg::SW_OTHER : fpsm_pkg::SW_ARM);
		if (cfg_thr < 127 && $urandom_range(0, 6) != 0)
			t.stick_throttle = 8'(cfg_thr + 1 + $urandom_range(0, 126 - cfg_thr));
		send_tick(t);
		n = $urandom_range(1, 6);
		repeat (n) send_tick(flight_tick(fpsm_pkg::SW_ARM));
		t = flight_tick(fpsm_pkg::SW_LAND);
		if ($urandom_range(0, 4) != 0) t.ground_range = 16'(above(cfg_land_h));
		send_tick(t);
		n = $urandom_range(0, cfg_hold + 3);
		repeat (n) begin
			t = flight_tick(fpsm_pkg::SW_LAND);
			if (cfg_touchdown_h > 0 && $urandom_range(0, 6) != 0)
				t.ground_range = 16'($urandom_range(0, cfg_touchdown_h - 1));
			send_tick(t);
		end
		if ($urandom_range(0, 2) == 0) begin
			t = flight_tick(fpsm_pkg::SW_ARM);
			t.stick_throttle = fpsm_pkg::STICK_LOW;
			if (cfg_touchdown_h > 0)
				t.ground_range = 16'($urandom_range(0, cfg_touchdown_h - 1));
			send_tick(t);
		end
	endtask

	task automatic random_config();
		int to_h;
		int td_h;
		int land_h;
		int tilt;
		int hold;
		int thr;
		to_h = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 1000);
		td_h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 100);
		land_h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1500);
		case ($urandom_range(0, 5))
			0: tilt = 32767;
			1: tilt = 0;
			default: tilt = $urandom_range(0, 18000);
		endcase
		hold = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
		thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) - 128
			: $urandom_range(0, 60) - 20;
		set_config(to_h, td_h, land_h, tilt, hold, thr);
	endtask

	task automatic test_directed();
		fpsm_pkg::item_t t;
		reg_check(fpsm_pkg::REG_TAKEOFF_HEIGHT, fpsm_pkg::RST_TAKEOFF_HEIGHT, 32'hFFFF);
		reg_check(fpsm_pkg::REG_TOUCHDOWN_HEIGHT, fpsm_pkg::RST_TOUCHDOWN_HEIGHT, 32'hFFFF);
		reg_check(fpsm_pkg::REG_LANDING_HEIGHT, fpsm_pkg::RST_LANDING_HEIGHT, 32'hFFFF);
		reg_check(fpsm_pkg::REG_TILT_LIMIT, fpsm_pkg::RST_TILT_LIMIT, 32'h7FFF);
		reg_check(fpsm_pkg::REG_HOLD_TICKS, fpsm_pkg::RST_HOLD_TICKS, 32'h3F);
		reg_check(fpsm_pkg::REG_LIFTOFF_THR, 32'($signed(fpsm_pkg::RST_LIFTOFF_THR)),
			32'hFF);
		bus_idle();
		set_config(fpsm_pkg::RST_TAKEOFF_HEIGHT, fpsm_pkg::RST_TOUCHDOWN_HEIGHT,
			fpsm_pkg::RST_LANDING_HEIGHT, fpsm_pkg::RST_TILT_LIMIT, 1,
			fpsm_pkg::RST_LIFTOFF_THR);

		send_tick(quiet_tick(fpsm_pkg::SW_ARM));       // arm refused before calibration
		t = quiet_tick(fpsm_pkg::SW_DISARM);
		t.calibration_pass = 1'b1;
		send_tick(t);
		send_tick(quiet_tick(fpsm_pkg::SW_ARM));
		send_tick(with_pattern(quiet_tick(fpsm_pkg::SW_ARM)));
		t = quiet_tick(fpsm_pkg::SW_OTHER);
		t.stick_throttle = 8'sd127;
		send_tick(t);                                  // ready exit to testing
		send_tick(quiet_tick(fpsm_pkg::SW_OTHER));
		send_tick(quiet_tick(fpsm_pkg::SW_DISARM));
		send_tick(quiet_tick(fpsm_pkg::SW_ARM));
		send_tick(with_pattern(quiet_tick(fpsm_pkg::SW_ARM)));
		t = quiet_tick(fpsm_pkg::SW_ARM);
		t.stick_throttle = 8'sd6;
		t.ground_range = 16'd100;
		send_tick(t);
		t = quiet_tick(fpsm_pkg::SW_ARM);
		t.ground_range = 16'd101;
		t.roll_angle = 16'sd6000;
		t.pitch_angle = -16'sd6000;
		send_tick(t);
		t = quiet_tick(fpsm_pkg::SW_LAND);
		t.ground_range = 16'd500;
		send_tick(t);
		t = quiet_tick(fpsm_pkg::SW_ARM);
		t.ground_range = 16'd501;
		send_tick(t);
		t = quiet_tick(fpsm_pkg::SW_LAND);
		t.ground_range = 16'd501;
		send_tick(t);
		t = quiet_tick(fpsm_pkg::SW_LAND);
		t.ground_range = 16'd9;
		send_tick(t);
		send_tick(quiet_tick(fpsm_pkg::SW_OTHER));     // hold expired, but switch left landing
		t = quiet_tick(fpsm_pkg::SW_OTHER);
		t.ground_range = 16'd9;
		t.stick_throttle = fpsm_pkg::STICK_LOW;
		send_tick(t);
		send_tick(quiet_tick(fpsm_pkg::SW_DISARM));
		send_tick(with_pattern(quiet_tick(fpsm_pkg::SW_ARM)));
		t = quiet_tick(fpsm_pkg::SW_ARM);
		t.stick_throttle = 8'sd127;
		t.ground_range = 16'hFFFF;
		t.roll_angle = -16'sd32768;
		t.pitch_angle = 16'sd32767;
		send_tick(t);
		t = '1;
		t.stick_roll = -8'sd128;
		t.stick_yaw = -8'sd128;
		t.roll_angle = 16'sd32767;
		send_tick(t);
		drain();
	endtask

	task automatic test_register_extremes();
		set_config(65535, 65535, 65535, 32767, 63, 127);
		repeat (8) fly();
		set_config(0, 0, 0, 0, 0, -128);
		repeat (8) fly();
		set_config(0, 65535, 0, 18000, 63, -128);
		repeat (4) fly();
	endtask

	task automatic test_backpressure();
		set_config(50, 20, 200, 9000, 3, 0);
		rx_hold_req = 1'b1;
		tx_fast = 1'b1;
		repeat (3) fly();
		tx_fast = 1'b0;
		drain();
	endtask

	task automatic test_random();
		int next_cfg;
		int target;
		target = ticks_sent + RANDOM_TICKS;
		next_cfg = ticks_sent;
		while (ticks_sent < target) begin
			if (ticks_sent >= next_cfg) begin
				random_config();
				next_cfg = ticks_sent + $urandom_range(120, 250);
			end
			tx_fast = ($urandom_range(0, 4) == 0);
			rx_fast = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 6) != 0)
				fly();
			else
				repeat ($urandom_range(1, 10)) send_tick(noise_tick());
		end
		tx_fast = 1'b0;
		rx_fast = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_random();
		drain();
		if (mismatch_cnt == 0) begin
			$display("[flight_phase_state_machine] OK");
		end else begin
			$display("[flight_phase_state_machine] ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fpsm_pkg.sv
hw/rtl/fpsm_regs.sv
hw/rtl/fpsm_core.sv
hw/rtl/flight_phase_state_machine.sv
hw/rtl/fpsm_checker.sv
dv/tb_top.sv
